FILE: rtl/core/gcl_pkg.sv
// Package for the grid cell locator: widths, register indexes and shared types.
package gcl_pkg;

   localparam int MAX_CELLS  = 255;
   localparam int FRAC_BITS  = 16;
   localparam int POS_W      = 32;
   localparam int INV_W      = 23;
   localparam int GRID_W     = 8;
   localparam int CELL_W     = 8;
   localparam int FRAC_W     = FRAC_BITS + 1;
   localparam int PROD_W     = POS_W + INV_W;
   localparam int SCALE_W    = PROD_W - (POS_W - FRAC_BITS);
   localparam int IDX_X_W    = 24;
   localparam int IDX_Y_W    = 25;
   localparam int IDX_Z_W    = 26;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PIPE_DEPTH = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_SPACING = 3'd0,
      CSR_Z_BASE      = 3'd1,
      CSR_BOX_X       = 3'd2,
      CSR_BOX_Y       = 3'd3,
      CSR_Z_TOP       = 3'd4,
      CSR_GRID_X      = 3'd5,
      CSR_GRID_Y      = 3'd6,
      CSR_GRID_Z      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [INV_W-1:0]        inv_spacing;
      logic signed [POS_W-1:0] z_base;
      logic signed [POS_W-1:0] box_x;
      logic signed [POS_W-1:0] box_y;
      logic signed [POS_W-1:0] z_top;
      logic [GRID_W-1:0]       grid_x;
      logic [GRID_W-1:0]       grid_y;
      logic [GRID_W-1:0]       grid_z;
   } cfg_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic [CELL_W-1:0] cell_z;
      logic [FRAC_W-1:0] frac_x;
      logic [FRAC_W-1:0] frac_y;
      logic [FRAC_W-1:0] frac_z;
   } loc_type;

   function automatic logic [GRID_W-1:0] eff_grid(input logic [GRID_W-1:0] g);
      logic [GRID_W-1:0] r;
      r = g;
      if (g == '0) begin
         r = GRID_W'(1);
      end else if (int'(g) > MAX_CELLS) begin
         r = GRID_W'(MAX_CELLS);
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/grid_cell_locator_top.sv
// Top level of the grid cell locator: config registers, three axis lanes, index stages.
// Takes one probe position per clock; from the start beat to the rsp_valid beat
// each item passes three stages in each axis lane (offset and edge compare,
// scale multiply, clamp) and three in the index path (two multiply-add stages,
// then the component adds). busy is always low. rsp_valid is high for exactly
// one cycle per result and the outputs are valid only then; the receiver cannot
// stall, so every result must be taken in that cycle.
// Write the csr_ registers only while no item is in flight.
module grid_cell_locator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [gcl_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [gcl_pkg::POS_W-1:0]  req_pos_y,
   input  logic signed [gcl_pkg::POS_W-1:0]  req_pos_z,
   output logic                              rsp_valid,
   output logic [gcl_pkg::CELL_W-1:0]        rsp_cell_x,
   output logic [gcl_pkg::CELL_W-1:0]        rsp_cell_y,
   output logic [gcl_pkg::CELL_W-1:0]        rsp_cell_z,
   output logic [gcl_pkg::FRAC_W-1:0]        rsp_frac_x,
   output logic [gcl_pkg::FRAC_W-1:0]        rsp_frac_y,
   output logic [gcl_pkg::FRAC_W-1:0]        rsp_frac_z,
   output logic [gcl_pkg::IDX_X_W-1:0]       rsp_index_fx,
   output logic [gcl_pkg::IDX_Y_W-1:0]       rsp_index_fy,
   output logic [gcl_pkg::IDX_Z_W-1:0]       rsp_index_fz,
   input  logic                              csr_we,
   input  logic [gcl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gcl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gcl_pkg::*;

   localparam int LOC_DLY = 3;

   cfg_type           cfg;
   loc_type           loc;
   loc_type           loc_ff [LOC_DLY];
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;

   assign busy = 1'b0;

   gcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gcl_axis u_axis_x (
      .clock       (clock),
      .pos         (req_pos_x),
      .offset      ('0),
      .upper       (cfg.box_x),
      .inv_spacing (cfg.inv_spacing),
      .grid        (cfg.grid_x),
      .cell_idx    (loc.cell_x),
      .frac        (loc.frac_x)
   );

   gcl_axis u_axis_y (
      .clock       (clock),
      .pos         (req_pos_y),
      .offset      ('0),
      .upper       (cfg.box_y),
      .inv_spacing (cfg.inv_spacing),
      .grid        (cfg.grid_y),
      .cell_idx    (loc.cell_y),
      .frac        (loc.frac_y)
   );

   gcl_axis u_axis_z (
      .clock       (clock),
      .pos         (req_pos_z),
      .offset      (cfg.z_base),
      .upper       (cfg.z_top),
      .inv_spacing (cfg.inv_spacing),
      .grid        (cfg.grid_z),
      .cell_idx    (loc.cell_z),
      .frac        (loc.frac_z)
   );

   gcl_index u_index (
      .clock    (clock),
      .cell_x   (loc.cell_x),
      .cell_y   (loc.cell_y),
      .cell_z   (loc.cell_z),
      .cfg      (cfg),
      .index_fx (rsp_index_fx),
      .index_fy (rsp_index_fy),
      .index_fz (rsp_index_fz)
   );

   // cell/frac ride alongside the index stages
   always_ff @(posedge clock) begin
      loc_ff[0] <= loc;
      for (int i = 1; i < LOC_DLY; i++) begin
         loc_ff[i] <= loc_ff[i-1];
      end
   end

   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid  = valid_ff[PIPE_DEPTH-1];
   assign rsp_cell_x = loc_ff[LOC_DLY-1].cell_x;
   assign rsp_cell_y = loc_ff[LOC_DLY-1].cell_y;
   assign rsp_cell_z = loc_ff[LOC_DLY-1].cell_z;
   assign rsp_frac_x = loc_ff[LOC_DLY-1].frac_x;
   assign rsp_frac_y = loc_ff[LOC_DLY-1].frac_y;
   assign rsp_frac_z = loc_ff[LOC_DLY-1].frac_z;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, PIPE_DEPTH))
      else $error("result beat without a start beat at fixed latency");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_index_fz - IDX_Z_W'(rsp_index_fy)) ==
                     (IDX_Z_W'(rsp_index_fy) - IDX_Z_W'(rsp_index_fx))))
      else $error("force component indexes not one grid volume apart");

   a_frac_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frac_x[FRAC_BITS]) |-> (rsp_frac_x[FRAC_BITS-1:0] == '0))
      else $error("fraction above one on x");

   a_cell_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frac_z[FRAC_BITS]) |-> (rsp_cell_z < cfg.grid_z))
      else $error("cell at upper edge beyond last cell on z");

endmodule

FILE: rtl/core/gcl_csr.sv
// Configuration registers of the grid cell locator, with effective grid sizes.
module gcl_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [gcl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gcl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output gcl_pkg::cfg_type                 cfg
);
   import gcl_pkg::*;

   logic [INV_W-1:0]        inv_spacing_ff;
   logic signed [POS_W-1:0] z_base_ff;
   logic signed [POS_W-1:0] box_x_ff;
   logic signed [POS_W-1:0] box_y_ff;
   logic signed [POS_W-1:0] z_top_ff;
   logic [GRID_W-1:0]       grid_x_ff;
   logic [GRID_W-1:0]       grid_y_ff;
   logic [GRID_W-1:0]       grid_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_spacing_ff <= INV_W'(65536);
         z_base_ff      <= '0;
         box_x_ff       <= '0;
         box_y_ff       <= '0;
         z_top_ff       <= '0;
         grid_x_ff      <= GRID_W'(1);
         grid_y_ff      <= GRID_W'(1);
         grid_z_ff      <= GRID_W'(1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_INV_SPACING: inv_spacing_ff <= csr_wdata[INV_W-1:0];
            CSR_Z_BASE:      z_base_ff      <= csr_wdata;
            CSR_BOX_X:       box_x_ff       <= csr_wdata;
            CSR_BOX_Y:       box_y_ff       <= csr_wdata;
            CSR_Z_TOP:       z_top_ff       <= csr_wdata;
            CSR_GRID_X:      grid_x_ff      <= csr_wdata[GRID_W-1:0];
            CSR_GRID_Y:      grid_y_ff      <= csr_wdata[GRID_W-1:0];
            CSR_GRID_Z:      grid_z_ff      <= csr_wdata[GRID_W-1:0];
         endcase
      end
   end

   always_comb begin
      cfg.inv_spacing = inv_spacing_ff;
      cfg.z_base      = z_base_ff;
      cfg.box_x       = box_x_ff;
      cfg.box_y       = box_y_ff;
      cfg.z_top       = z_top_ff;
      cfg.grid_x      = eff_grid(grid_x_ff);
      cfg.grid_y      = eff_grid(grid_y_ff);
      cfg.grid_z      = eff_grid(grid_z_ff);
   end

endmodule

FILE: rtl/core/gcl_axis.sv
// One axis lane: offset and edge test, scale multiply, then cell/fraction with clamping.
module gcl_axis (
   input  logic                             clock,
   input  logic signed [gcl_pkg::POS_W-1:0] pos,
   input  logic signed [gcl_pkg::POS_W-1:0] offset,
   input  logic signed [gcl_pkg::POS_W-1:0] upper,
   input  logic [gcl_pkg::INV_W-1:0]        inv_spacing,
   input  logic [gcl_pkg::GRID_W-1:0]       grid,
   output logic [gcl_pkg::CELL_W-1:0]       cell_idx,
   output logic [gcl_pkg::FRAC_W-1:0]       frac
);
   import gcl_pkg::*;

   localparam int D_W   = POS_W + 1;

   // stage 1: offset position, edge compare
   logic signed [D_W-1:0] d_in, d_ff;
   logic                  above_s1_ff;
   // stage 2: scale product
   logic [PROD_W-1:0]     prod_in, prod_ff;
   logic                  neg_s2_ff, above_s2_ff;
   // stage 3: cell and fraction
   logic [SCALE_W-1:0]    scaled, clamped, lim;
   logic [CELL_W-1:0]     cell_in, cell_ff;
   logic [FRAC_W-1:0]     frac_in, frac_ff;

   assign d_in = D_W'(pos) - D_W'(offset);

   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      above_s1_ff <= (pos > upper);
   end

   assign prod_in = d_ff[POS_W-1:0] * inv_spacing;

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      neg_s2_ff   <= d_ff[D_W-1];
      above_s2_ff <= above_s1_ff;
   end

   always_comb begin
      scaled  = prod_ff[PROD_W-1:POS_W-FRAC_BITS];
      lim     = SCALE_W'({grid, {FRAC_BITS{1'b0}}});
      clamped = (scaled > lim) ? lim : scaled;
      priority if (above_s2_ff) begin
         cell_in = CELL_W'(grid - GRID_W'(1));
         frac_in = FRAC_W'(1) << FRAC_BITS;
      end else if (neg_s2_ff) begin
         cell_in = '0;
         frac_in = '0;
      end else begin
         cell_in = clamped[FRAC_BITS +: CELL_W];
         frac_in = FRAC_W'(clamped[FRAC_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      frac_ff <= frac_in;
   end

   assign cell_idx = cell_ff;
   assign frac     = frac_ff;

endmodule

FILE: rtl/core/gcl_index.sv
// Linear store index of the three force components, three register stages.
module gcl_index (
   input  logic                            clock,
   input  logic [gcl_pkg::CELL_W-1:0]      cell_x,
   input  logic [gcl_pkg::CELL_W-1:0]      cell_y,
   input  logic [gcl_pkg::CELL_W-1:0]      cell_z,
   input  gcl_pkg::cfg_type                cfg,
   output logic [gcl_pkg::IDX_X_W-1:0]     index_fx,
   output logic [gcl_pkg::IDX_Y_W-1:0]     index_fy,
   output logic [gcl_pkg::IDX_Z_W-1:0]     index_fz
);
   import gcl_pkg::*;

   localparam int GP_W   = GRID_W + 1;
   localparam int ROW_W  = CELL_W + GP_W;
   localparam int T_W    = 2 * CELL_W;
   localparam int AREA_W = 2 * GP_W;
   localparam int VOL_W  = 3 * GP_W;

   logic [GP_W-1:0]   gx1, gy1, gz1;
   logic [ROW_W-1:0]  t_full;
   logic [T_W-1:0]    t_ff;
   logic [AREA_W-1:0] area_ff;
   logic [CELL_W-1:0] cz_ff;
   logic [VOL_W-1:0]  vol_full;
   logic [T_W+GP_W-1:0] ix_full;
   logic [IDX_X_W-1:0] ix_ff;
   logic [IDX_Y_W-1:0] npts_ff;
   logic [IDX_X_W-1:0] fx_ff;
   logic [IDX_Y_W-1:0] fy_ff;
   logic [IDX_Z_W-1:0] fz_ff;

   assign gx1 = GP_W'(cfg.grid_x) + GP_W'(1);
   assign gy1 = GP_W'(cfg.grid_y) + GP_W'(1);
   assign gz1 = GP_W'(cfg.grid_z) + GP_W'(1);

   assign t_full = ROW_W'(cell_x) * ROW_W'(gy1) + ROW_W'(cell_y);

   always_ff @(posedge clock) begin
      t_ff    <= t_full[T_W-1:0];
      area_ff <= AREA_W'(gx1) * AREA_W'(gy1);
      cz_ff   <= cell_z;
   end

   assign ix_full  = (T_W+GP_W)'(t_ff) * (T_W+GP_W)'(gz1) + (T_W+GP_W)'(cz_ff);
   assign vol_full = VOL_W'(area_ff) * VOL_W'(gz1);

   always_ff @(posedge clock) begin
      ix_ff   <= ix_full[IDX_X_W-1:0];
      npts_ff <= vol_full[IDX_Y_W-1:0];
   end

   always_ff @(posedge clock) begin
      fx_ff <= ix_ff;
      fy_ff <= IDX_Y_W'(ix_ff) + npts_ff;
      fz_ff <= IDX_Z_W'(ix_ff) + IDX_Z_W'({npts_ff, 1'b0});
   end

   assign index_fx = fx_ff;
   assign index_fy = fy_ff;
   assign index_fz = fz_ff;

endmodule

FILE: tb/tb_grid_cell_locator_top.sv
// Self-checking testbench for grid_cell_locator_top: directed and random probe lookups.
module tb_grid_cell_locator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gcl_pkg::*;

   localparam int ONE         = 1 << FRAC_BITS;
   localparam int QUIET_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [CELL_W-1:0]  cell_x;
      logic [CELL_W-1:0]  cell_y;
      logic [CELL_W-1:0]  cell_z;
      logic [FRAC_W-1:0]  frac_x;
      logic [FRAC_W-1:0]  frac_y;
      logic [FRAC_W-1:0]  frac_z;
      logic [IDX_X_W-1:0] index_fx;
      logic [IDX_Y_W-1:0] index_fy;
      logic [IDX_Z_W-1:0] index_fz;
   } cell_lookup_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_idx;
      logic [FRAC_W-1:0] frac;
   } axis_hit_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [POS_W-1:0]   req_pos_x = '0;
   logic signed [POS_W-1:0]   req_pos_y = '0;
   logic signed [POS_W-1:0]   req_pos_z = '0;
   logic                      rsp_valid;
   logic [CELL_W-1:0]         rsp_cell_x;
   logic [CELL_W-1:0]         rsp_cell_y;
   logic [CELL_W-1:0]         rsp_cell_z;
   logic [FRAC_W-1:0]         rsp_frac_x;
   logic [FRAC_W-1:0]         rsp_frac_y;
   logic [FRAC_W-1:0]         rsp_frac_z;
   logic [IDX_X_W-1:0]        rsp_index_fx;
   logic [IDX_Y_W-1:0]        rsp_index_fy;
   logic [IDX_Z_W-1:0]        rsp_index_fz;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   cfg_type         grid_cfg;
   cell_lookup_type pending_lookups[$];
   int              mismatch_count = 0;
   int              sender_idle_pct = 0;
   int              quiet_cycles = 0;

   grid_cell_locator_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_pos_z    (req_pos_z),
      .rsp_valid    (rsp_valid),
      .rsp_cell_x   (rsp_cell_x),
      .rsp_cell_y   (rsp_cell_y),
      .rsp_cell_z   (rsp_cell_z),
      .rsp_frac_x   (rsp_frac_x),
      .rsp_frac_y   (rsp_frac_y),
      .rsp_frac_z   (rsp_frac_z),
      .rsp_index_fx (rsp_index_fx),
      .rsp_index_fy (rsp_index_fy),
      .rsp_index_fz (rsp_index_fz),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [GRID_W-1:0] cells_along(input logic [GRID_W-1:0] g);
      if (g == '0) begin
         return GRID_W'(1);
      end
      if (int'(g) > MAX_CELLS) begin
         return GRID_W'(MAX_CELLS);
      end
      return g;
   endfunction

   function automatic axis_hit_type locate_axis(input logic signed [POS_W:0] d,
                                                input bit above,
                                                input logic [GRID_W-1:0] g);
      axis_hit_type hit;
      logic [63:0]  scaled;
      logic [63:0]  limit;
      limit = 64'(g) << FRAC_BITS;
      if (above) begin
         hit.cell_idx = CELL_W'(g - 1);
         hit.frac     = FRAC_W'(1) << FRAC_BITS;
      end else if (d < 0) begin
         hit.cell_idx = '0;
         hit.frac     = '0;
      end else begin
         scaled = (64'(d[POS_W-1:0]) * 64'(grid_cfg.inv_spacing)) >> (32 - FRAC_BITS);
         if (scaled > limit) begin
            scaled = limit;
         end
         hit.cell_idx = scaled[FRAC_BITS +: CELL_W];
         hit.frac     = {1'b0, scaled[FRAC_BITS-1:0]};
      end
      return hit;
   endfunction

   function automatic cell_lookup_type predict_lookup(input logic signed [POS_W-1:0] px,
                                                      input logic signed [POS_W-1:0] py,
                                                      input logic signed [POS_W-1:0] pz);
      logic signed [POS_W-1:0] zb;
      logic signed [POS_W-1:0] bx;
      logic signed [POS_W-1:0] by;
      logic signed [POS_W-1:0] zt;
      logic signed [POS_W:0]   dz;
      logic [GRID_W-1:0]       gx;
      logic [GRID_W-1:0]       gy;
      logic [GRID_W-1:0]       gz;
      axis_hit_type            hx;
      axis_hit_type            hy;
      axis_hit_type            hz;
      logic [63:0]             points;
      logic [63:0]             base;
      cell_lookup_type         r;
      zb = grid_cfg.z_base;
      bx = grid_cfg.box_x;
      by = grid_cfg.box_y;
      zt = grid_cfg.z_top;
      gx = cells_along(grid_cfg.grid_x);
      gy = cells_along(grid_cfg.grid_y);
      gz = cells_along(grid_cfg.grid_z);
      dz = $signed({pz[POS_W-1], pz}) - $signed({zb[POS_W-1], zb});
      hx = locate_axis({px[POS_W-1], px}, px > bx, gx);
      hy = locate_axis({py[POS_W-1], py}, py > by, gy);
      hz = locate_axis(dz, pz > zt, gz);
      points = (64'(gx) + 64'd1) * (64'(gy) + 64'd1) * (64'(gz) + 64'd1);
      base = (64'(hx.cell_idx) * (64'(gy) + 64'd1) + 64'(hy.cell_idx)) * (64'(gz) + 64'd1)
             + 64'(hz.cell_idx);
      r.cell_x   = hx.cell_idx;
      r.cell_y   = hy.cell_idx;
      r.cell_z   = hz.cell_idx;
      r.frac_x   = hx.frac;
      r.frac_y   = hy.frac;
      r.frac_z   = hz.frac;
      r.index_fx = IDX_X_W'(base);
      r.index_fy = IDX_Y_W'(base + points);
      r.index_fz = IDX_Z_W'(base + 2 * points);
      return r;
   endfunction

   function automatic string describe(input cell_lookup_type v);
      return $sformatf("cell %0d/%0d/%0d frac %h/%h/%h index %h/%h/%h",
                       v.cell_x, v.cell_y, v.cell_z, v.frac_x, v.frac_y, v.frac_z,
                       v.index_fx, v.index_fy, v.index_fz);
   endfunction

   function automatic logic [31:0] sat32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // position extent of g cells at the given reciprocal spacing, capped at 2^31
   function automatic longint grid_extent(input logic [31:0] g_word, input logic [31:0] inv_word);
      longint g;
      longint inv;
      longint v;
      g = longint'(cells_along(g_word[GRID_W-1:0]));
      inv = longint'(inv_word[INV_W-1:0]);
      if (inv == 0) begin
         return 64'sd2147483648;
      end
      v = (g << 32) / inv;
      return (v > 64'sd2147483648) ? 64'sd2147483648 : v;
   endfunction

   function automatic logic [31:0] jitter_around(input longint centre, input longint spread);
      longint pick;
      pick = longint'($urandom_range(32'(spread / 2), 0));
      return sat32(centre - spread / 4 + pick);
   endfunction

   function automatic logic [31:0] near_axis(input longint lo, input longint hi);
      longint      span;
      longint      pick;
      int unsigned r;
      span = hi - lo;
      if (span < ONE) begin
         span = ONE;
      end
      if (span > 64'sd2147483648) begin
         span = 64'sd2147483648;
      end
      r = $urandom_range(99, 0);
      if (r < 15) begin
         return $urandom();
      end
      if (r < 27) begin
         case ($urandom_range(3, 0))
            0: begin
               return sat32(lo);
            end
            1: begin
               return sat32(lo - 1);
            end
            2: begin
               return sat32(hi);
            end
            default: begin
               return sat32(hi + 1);
            end
         endcase
      end
      pick = longint'($urandom_range(32'(span + span / 4), 0));
      return sat32(lo - span / 8 + pick);
   endfunction

   function automatic logic [31:0] grid_word();
      logic [31:0] w;
      int unsigned r;
      r = $urandom_range(99, 0);
      w = $urandom();
      if ($urandom_range(3, 0) != 0) begin
         w[31:8] = '0;
      end
      if (r < 8) begin
         w[7:0] = 8'd0;
      end else if (r < 16) begin
         w[7:0] = 8'(MAX_CELLS);
      end else begin
         w[7:0] = 8'($urandom_range(MAX_CELLS, 1));
      end
      return w;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [31:0] word);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      @(posedge clock);
      case (idx)
         CSR_INV_SPACING: begin
            grid_cfg.inv_spacing = word[INV_W-1:0];
         end
         CSR_Z_BASE: begin
            grid_cfg.z_base = word;
         end
         CSR_BOX_X: begin
            grid_cfg.box_x = word;
         end
         CSR_BOX_Y: begin
            grid_cfg.box_y = word;
         end
         CSR_Z_TOP: begin
            grid_cfg.z_top = word;
         end
         CSR_GRID_X: begin
            grid_cfg.grid_x = word[GRID_W-1:0];
         end
         CSR_GRID_Y: begin
            grid_cfg.grid_y = word[GRID_W-1:0];
         end
         default: begin
            grid_cfg.grid_z = word[GRID_W-1:0];
         end
      endcase
   endtask

   task automatic write_config(input logic [31:0] inv_w, input logic [31:0] zb_w,
                               input logic [31:0] bx_w, input logic [31:0] by_w,
                               input logic [31:0] zt_w, input logic [31:0] gx_w,
                               input logic [31:0] gy_w, input logic [31:0] gz_w);
      write_reg(CSR_INV_SPACING, inv_w);
      write_reg(CSR_Z_BASE, zb_w);
      write_reg(CSR_BOX_X, bx_w);
      write_reg(CSR_BOX_Y, by_w);
      write_reg(CSR_Z_TOP, zt_w);
      write_reg(CSR_GRID_X, gx_w);
      write_reg(CSR_GRID_Y, gy_w);
      write_reg(CSR_GRID_Z, gz_w);
      csr_we <= 1'b0;
   endtask

   task automatic settle_pipeline();
      start <= 1'b0;
      while (pending_lookups.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_probe(input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
                             input logic signed [POS_W-1:0] pz);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      start     <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      pending_lookups.push_back(predict_lookup(px, py, pz));
   endtask

   task automatic randomize_registers();
      logic [31:0]     inv_w;
      logic [31:0]     zb_w;
      logic [31:0]     gx_w;
      logic [31:0]     gy_w;
      logic [31:0]     gz_w;
      logic [31:0]     bx_w;
      logic [31:0]     by_w;
      logic [31:0]     zt_w;
      logic signed [31:0] zb_s;
      int unsigned     r;
      r = $urandom_range(99, 0);
      if (r < 8) begin
         inv_w = '0;
      end else if (r < 16) begin
         inv_w = $urandom();
      end else if (r < 24) begin
         inv_w = 32'd6553600;
      end else begin
         inv_w = $urandom_range(6553600, 4096);
      end
      gx_w = grid_word();
      gy_w = grid_word();
      gz_w = grid_word();
      zb_w = ($urandom_range(99, 0) < 15) ? $urandom()
             : sat32(longint'($urandom_range(1 << 25, 0)) - (64'sd1 << 24));
      zb_s = zb_w;
      bx_w = ($urandom_range(99, 0) < 10) ? $urandom()
             : jitter_around(grid_extent(gx_w, inv_w), grid_extent(gx_w, inv_w));
      by_w = ($urandom_range(99, 0) < 10) ? $urandom()
             : jitter_around(grid_extent(gy_w, inv_w), grid_extent(gy_w, inv_w));
      zt_w = ($urandom_range(99, 0) < 10) ? $urandom()
             : jitter_around(longint'(zb_s) + grid_extent(gz_w, inv_w), grid_extent(gz_w, inv_w));
      write_config(inv_w, zb_w, bx_w, by_w, zt_w, gx_w, gy_w, gz_w);
   endtask

   task automatic test_default_registers();
      send_probe(0, 0, 0);
      send_probe(1, 1, 1);
      send_probe(-1, -1, -1);
      send_probe(32'h8000_0000, 32'h7FFF_FFFF, 0);
   endtask

   task automatic test_cell_edges();
      // half-angstrom spacing; x box lies past the last grid point, y grid of zero
      settle_pipeline();
      write_config(2 * ONE, -ONE, 6 * ONE, ONE / 2, ONE, 8, 0, 4);
      send_probe(0, 0, -ONE);
      send_probe(ONE + ONE / 4, ONE / 4, 0);
      send_probe(5 * ONE, ONE / 2, ONE);
      send_probe(6 * ONE + 1, ONE / 2 + 1, ONE + 1);
      send_probe(-1, -1, -ONE - 1);
      send_probe(1, 1, -ONE + 1);
      // upper edge below the origin: above-edge wins over below-origin
      settle_pipeline();
      write_config(2 * ONE, 3 * ONE, -2 * ONE, ONE / 2, ONE, 8, 0, 4);
      send_probe(-ONE, ONE / 4, 2 * ONE);
      send_probe(-3 * ONE, -1, 3 * ONE);
      send_probe(-2 * ONE, 0, 0);
   endtask

   task automatic test_register_extremes();
      settle_pipeline();
      write_config(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_probe(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_probe(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_probe(ONE, 1, 32'h8000_0001);
      send_probe(0, 32'h7FFF_FFFF, 0);
      settle_pipeline();
      write_config(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 255, 0);
      send_probe(32'h8000_0000, 0, 32'h7FFF_FFFF);
      send_probe(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
   endtask

   task automatic test_random_lookups(input int idle_pct, input int phases, input int per_phase);
      logic signed [31:0] zb;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] zt;
      for (int p = 0; p < phases; p++) begin
         settle_pipeline();
         randomize_registers();
         sender_idle_pct = idle_pct;
         zb = grid_cfg.z_base;
         bx = grid_cfg.box_x;
         by = grid_cfg.box_y;
         zt = grid_cfg.z_top;
         for (int i = 0; i < per_phase; i++) begin
            send_probe(near_axis(0, longint'(bx)), near_axis(0, longint'(by)),
                       near_axis(longint'(zb), longint'(zt)));
         end
      end
      sender_idle_pct = 0;
   endtask

   always @(posedge clock) begin : check_results
      cell_lookup_type seen;
      cell_lookup_type want;
      if (!reset && rsp_valid) begin
         seen = {rsp_cell_x, rsp_cell_y, rsp_cell_z, rsp_frac_x, rsp_frac_y, rsp_frac_z,
                 rsp_index_fx, rsp_index_fy, rsp_index_fz};
         if (pending_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: beat with no lookup pending: %s", $realtime, describe(seen));
            end
         end else begin
            want = pending_lookups.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: expected %s", $realtime, describe(want));
                  $display("%0t: actual   %s", $realtime, describe(seen));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      grid_cfg.inv_spacing = INV_W'(ONE);
      grid_cfg.z_base      = '0;
      grid_cfg.box_x       = '0;
      grid_cfg.box_y       = '0;
      grid_cfg.z_top       = '0;
      grid_cfg.grid_x      = GRID_W'(1);
      grid_cfg.grid_y      = GRID_W'(1);
      grid_cfg.grid_z      = GRID_W'(1);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_registers();
      test_cell_edges();
      test_register_extremes();
      test_random_lookups(16, 5, 82);
      test_random_lookups(53, 5, 82);
      test_random_lookups(0, 5, 82);
      settle_pipeline();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (mismatch_count == 0 && pending_lookups.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: grid_cell_locator_top.f
rtl/core/gcl_pkg.sv
rtl/core/gcl_csr.sv
rtl/core/gcl_axis.sv
rtl/core/gcl_index.sv
rtl/core/grid_cell_locator_top.sv
tb/tb_grid_cell_locator_top.sv
